FILE: rtl/core/bff_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bff_pkg
// Shared types and step codes of the flocking force block.
// ----------------------------------------------------------------------------
package bff_pkg;

  localparam int unsigned CoordW  = 24;
  localparam int unsigned DiffW   = 25;
  localparam int unsigned SqW     = 50;
  localparam int unsigned RootW   = 25;
  localparam int unsigned NumW    = 56;
  localparam int unsigned AccW    = 48;
  localparam int unsigned WeightW = 16;
  localparam int unsigned ForceW  = 32;
  localparam int unsigned ProdW   = 65;
  localparam int unsigned WsumW   = 60;
  localparam int unsigned SepGain = 100;

  // register indexes
  localparam logic [2:0] REG_SEP_W = 3'd0;
  localparam logic [2:0] REG_COH_W = 3'd1;
  localparam logic [2:0] REG_ALI_W = 3'd2;
  localparam logic [2:0] REG_SEP_R = 3'd3;
  localparam logic [2:0] REG_COH_R = 3'd4;
  localparam logic [2:0] REG_ALI_R = 3'd5;

  // squaring steps
  localparam logic [2:0] MUL_DX = 3'd0;
  localparam logic [2:0] MUL_DY = 3'd1;
  localparam logic [2:0] MUL_VX = 3'd2;
  localparam logic [2:0] MUL_VY = 3'd3;
  localparam logic [2:0] MUL_SR = 3'd4;
  localparam logic [2:0] MUL_CR = 3'd5;
  localparam logic [2:0] MUL_AR = 3'd6;

  // jobs of the shared root and divide unit
  localparam logic [2:0] JOB_DIST  = 3'd0;
  localparam logic [2:0] JOB_VLEN  = 3'd1;
  localparam logic [2:0] JOB_SEP_X = 3'd2;
  localparam logic [2:0] JOB_SEP_Y = 3'd3;
  localparam logic [2:0] JOB_COH_X = 3'd4;
  localparam logic [2:0] JOB_COH_Y = 3'd5;
  localparam logic [2:0] JOB_ALI_X = 3'd6;
  localparam logic [2:0] JOB_ALI_Y = 3'd7;

  // final weighting steps, one per accumulator
  localparam logic [2:0] FIN_LAST = 3'd5;

  typedef struct packed {
    logic [WeightW-1:0] sep_w;
    logic [WeightW-1:0] coh_w;
    logic [WeightW-1:0] ali_w;
    logic [CoordW-1:0]  sep_r;
    logic [CoordW-1:0]  coh_r;
    logic [CoordW-1:0]  ali_r;
  } bff_cfg_t;

  typedef struct packed {
    logic       load;
    logic       mul;
    logic       job_start;
    logic       job_store;
    logic       fin_mul;
    logic       fin_add;
    logic       emit;
    logic [2:0] sel;
  } bff_cmd_t;

  typedef struct packed {
    logic [7:0] job_en;
    logic       iter_done;
    logic       iter_busy;
    logic       last;
    logic       out_free;
  } bff_sts_t;

endpackage

FILE: rtl/core/bff_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bff_cfg
// APB register file: weights and radii, with read-back.
// ----------------------------------------------------------------------------
module bff_cfg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output bff_pkg::bff_cfg_t   cfg
);
  import bff_pkg::*;

  bff_cfg_t cfg_r;
  logic     wr;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[4:2];
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sep_w <= 16'd256;
      cfg_r.coh_w <= 16'd256;
      cfg_r.ali_w <= 16'd256;
      cfg_r.sep_r <= 24'd6400;
      cfg_r.coh_r <= 24'd12800;
      cfg_r.ali_r <= 24'd12800;
    end else if (wr) begin
      case (idx)
        REG_SEP_W: cfg_r.sep_w <= pwdata[WeightW-1:0];
        REG_COH_W: cfg_r.coh_w <= pwdata[WeightW-1:0];
        REG_ALI_W: cfg_r.ali_w <= pwdata[WeightW-1:0];
        REG_SEP_R: cfg_r.sep_r <= pwdata[CoordW-1:0];
        REG_COH_R: cfg_r.coh_r <= pwdata[CoordW-1:0];
        REG_ALI_R: cfg_r.ali_r <= pwdata[CoordW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SEP_W: prdata = {16'd0, cfg_r.sep_w};
      REG_COH_W: prdata = {16'd0, cfg_r.coh_w};
      REG_ALI_W: prdata = {16'd0, cfg_r.ali_w};
      REG_SEP_R: prdata = {8'd0, cfg_r.sep_r};
      REG_COH_R: prdata = {8'd0, cfg_r.coh_r};
      REG_ALI_R: prdata = {8'd0, cfg_r.ali_r};
      default:   prdata = 32'd0;
    endcase
  end

endmodule

FILE: rtl/core/bff_iter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bff_iter
// Shared iterative unit: restoring divide (one quotient bit per cycle) or
// integer square root (one root bit per cycle).
// ----------------------------------------------------------------------------
module bff_iter (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        is_sqrt,
  input  logic [bff_pkg::NumW-1:0]    num,
  input  logic [bff_pkg::SqW-1:0]     den,
  output logic                        busy,
  output logic                        done,
  output logic [bff_pkg::NumW-1:0]    quo,
  output logic [bff_pkg::RootW-1:0]   root
);
  import bff_pkg::*;

  logic [NumW-1:0]  x_r, x_nxt;
  logic [SqW:0]     rem_r, rem_nxt;
  logic [SqW-1:0]   den_r;
  logic [RootW-1:0] root_r, root_nxt;
  logic [5:0]       cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt, done_r, done_nxt, sq_r;

  logic [SqW:0]     dsh;
  logic [SqW+1:0]   dt;
  logic [RootW+3:0] ssh;
  logic [RootW+4:0] st;

  assign dsh = {rem_r[SqW-1:0], x_r[NumW-1]};
  assign dt  = {1'b0, dsh} - {2'b00, den_r};
  assign ssh = {rem_r[RootW+1:0], x_r[NumW-1 -: 2]};
  assign st  = {1'b0, ssh} - {3'b000, root_r, 2'b01};

  always_comb begin
    x_nxt    = x_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      x_nxt    = is_sqrt ? {den, 6'd0} : num;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = is_sqrt ? 6'(RootW - 1) : 6'(NumW - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (sq_r) begin
        x_nxt    = {x_r[NumW-3:0], 2'b00};
        rem_nxt  = st[RootW+4] ? {{(SqW-RootW-3){1'b0}}, ssh}
                               : {{(SqW-RootW-3){1'b0}}, st[RootW+3:0]};
        root_nxt = {root_r[RootW-2:0], ~st[RootW+4]};
      end else begin
        x_nxt   = {x_r[NumW-2:0], ~dt[SqW+1]};
        rem_nxt = dt[SqW+1] ? dsh : dt[SqW:0];
      end
      if (cnt_r == 6'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    if (start) begin
      den_r <= den;
      sq_r  <= is_sqrt;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = x_r;
  assign root = root_r;

endmodule

FILE: rtl/core/bff_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bff_dp
// Datapath: operand registers, squaring multiplier, shared root/divide unit,
// saturating accumulators, weighting and the result register.
// ----------------------------------------------------------------------------
module bff_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bff_pkg::bff_cfg_t                 cfg,
  input  bff_pkg::bff_cmd_t                 cmd,
  output bff_pkg::bff_sts_t                 sts,
  input  logic signed [bff_pkg::CoordW-1:0] in_self_x,
  input  logic signed [bff_pkg::CoordW-1:0] in_self_y,
  input  logic signed [bff_pkg::CoordW-1:0] in_other_x,
  input  logic signed [bff_pkg::CoordW-1:0] in_other_y,
  input  logic signed [bff_pkg::CoordW-1:0] in_other_vx,
  input  logic signed [bff_pkg::CoordW-1:0] in_other_vy,
  input  logic                              in_last_neighbor,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [bff_pkg::ForceW-1:0] out_force_x,
  output logic signed [bff_pkg::ForceW-1:0] out_force_y
);
  import bff_pkg::*;

  logic signed [DiffW-1:0]  dx_r, dy_r;
  logic signed [CoordW-1:0] vx_r, vy_r;
  logic                     last_r;
  logic [SqW-1:0]           sq_r, d2_r, v2_r;
  logic [AccW-1:0]          rs2_r, rc2_r, ra2_r;
  logic [RootW-1:0]         dist_r, vlen_r;
  logic signed [AccW-1:0]   acc_r [6];
  logic signed [ProdW-1:0]  prod_r;
  logic signed [WsumW-1:0]  wsum_r [2];
  logic                     out_valid_r;
  logic signed [ForceW-1:0] fx_r, fy_r;

  // squaring multiplier
  logic signed [DiffW-1:0]   mop;
  logic signed [2*DiffW-1:0] msq;
  logic [SqW-1:0]            msq_u;

  always_comb begin
    case (cmd.sel)
      MUL_DX:  mop = dx_r;
      MUL_DY:  mop = dy_r;
      MUL_VX:  mop = DiffW'(vx_r);
      MUL_VY:  mop = DiffW'(vy_r);
      MUL_SR:  mop = {1'b0, cfg.sep_r};
      MUL_CR:  mop = {1'b0, cfg.coh_r};
      MUL_AR:  mop = {1'b0, cfg.ali_r};
      default: mop = '0;
    endcase
  end
  assign msq   = mop * mop;
  assign msq_u = SqW'(msq);

  // job enables
  logic d2nz, sep_en, coh_en, ali_en;
  assign d2nz   = d2_r != '0;
  assign sep_en = d2nz && (d2_r < {2'b00, rs2_r});
  assign coh_en = d2nz && (d2_r < {2'b00, rc2_r});
  assign ali_en = d2nz && (d2_r < {2'b00, ra2_r}) && (v2_r != '0);

  // job operands
  logic [DiffW-1:0]  mdx, mdy;
  logic [CoordW-1:0] mvx, mvy;
  logic [DiffW-1:0]  msel;
  logic [31:0]       sep_mag;
  logic              is_sqrt, neg;
  logic [NumW-1:0]   num;
  logic [SqW-1:0]    den;

  assign mdx = dx_r[DiffW-1] ? DiffW'(-dx_r) : DiffW'(dx_r);
  assign mdy = dy_r[DiffW-1] ? DiffW'(-dy_r) : DiffW'(dy_r);
  assign mvx = vx_r[CoordW-1] ? CoordW'(-vx_r) : CoordW'(vx_r);
  assign mvy = vy_r[CoordW-1] ? CoordW'(-vy_r) : CoordW'(vy_r);
  assign msel    = cmd.sel[0] ? mdy : mdx;
  assign sep_mag = 32'(msel) * 32'(SepGain);

  always_comb begin
    is_sqrt = 1'b0;
    num     = '0;
    den     = d2_r;
    neg     = 1'b0;
    case (cmd.sel)
      JOB_DIST: begin
        is_sqrt = 1'b1;
      end
      JOB_VLEN: begin
        is_sqrt = 1'b1;
        den     = v2_r;
      end
      JOB_SEP_X, JOB_SEP_Y: begin
        num = {sep_mag, 24'd0};
        neg = cmd.sel[0] ? ~dy_r[DiffW-1] : ~dx_r[DiffW-1];
      end
      JOB_COH_X, JOB_COH_Y: begin
        num = {15'd0, msel, 16'd0};
        den = {25'd0, dist_r};
        neg = cmd.sel[0] ? dy_r[DiffW-1] : dx_r[DiffW-1];
      end
      JOB_ALI_X, JOB_ALI_Y: begin
        num = {16'd0, (cmd.sel[0] ? mvy : mvx), 16'd0};
        den = {25'd0, vlen_r};
        neg = cmd.sel[0] ? vy_r[CoordW-1] : vx_r[CoordW-1];
      end
      default: ;
    endcase
  end

  logic                iter_busy, iter_done;
  logic [NumW-1:0]     quo;
  logic [RootW-1:0]    root;

  bff_iter u_iter (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.job_start),
    .is_sqrt (is_sqrt),
    .num     (num),
    .den     (den),
    .busy    (iter_busy),
    .done    (iter_done),
    .quo     (quo),
    .root    (root)
  );

  // accumulator access, one address for store and weighting
  logic [2:0]             asel;
  logic signed [AccW-1:0] acc_rd, mag, term;
  logic signed [AccW:0]   asum;
  logic signed [AccW-1:0] asat;

  assign asel   = cmd.job_store ? (cmd.sel - 3'd2) : cmd.sel;
  assign acc_rd = acc_r[asel];
  assign mag    = {1'b0, quo[AccW-2:0]};
  assign term   = neg ? -mag : mag;
  assign asum   = {acc_rd[AccW-1], acc_rd} + {term[AccW-1], term};
  always_comb begin
    if (asum[AccW] != asum[AccW-1])
      asat = asum[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
    else
      asat = asum[AccW-1:0];
  end

  // weighting
  logic [WeightW-1:0]         wsel;
  logic signed [ProdW-1:0]    pbias;
  logic signed [ProdW-9:0]    wq;
  logic signed [WsumW-1:0]    wcur;

  always_comb begin
    case (cmd.sel[2:1])
      2'd0:    wsel = cfg.sep_w;
      2'd1:    wsel = cfg.coh_w;
      default: wsel = cfg.ali_w;
    endcase
  end
  assign pbias = prod_r + (prod_r[ProdW-1] ? ProdW'(255) : ProdW'(0));
  assign wq    = pbias[ProdW-1:8];
  assign wcur  = wsum_r[cmd.sel[0]];

  // saturation to the output width
  function automatic logic signed [ForceW-1:0] sat_force(logic signed [WsumW-1:0] v);
    logic signed [WsumW-1:0] hi, lo;
    hi = WsumW'(32'sh7FFFFFFF);
    lo = -hi - WsumW'(1);
    if (v > hi)      sat_force = ForceW'(hi);
    else if (v < lo) sat_force = ForceW'(lo);
    else             sat_force = v[ForceW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dx_r   <= DiffW'(in_other_x) - DiffW'(in_self_x);
      dy_r   <= DiffW'(in_other_y) - DiffW'(in_self_y);
      vx_r   <= in_other_vx;
      vy_r   <= in_other_vy;
      last_r <= in_last_neighbor;
    end
    if (cmd.mul) begin
      case (cmd.sel)
        MUL_DX:  sq_r  <= msq_u;
        MUL_DY:  d2_r  <= sq_r + msq_u;
        MUL_VX:  sq_r  <= msq_u;
        MUL_VY:  v2_r  <= sq_r + msq_u;
        MUL_SR:  rs2_r <= msq_u[AccW-1:0];
        MUL_CR:  rc2_r <= msq_u[AccW-1:0];
        MUL_AR:  ra2_r <= msq_u[AccW-1:0];
        default: ;
      endcase
    end
    if (cmd.job_store) begin
      if (cmd.sel == JOB_DIST) dist_r <= root;
      if (cmd.sel == JOB_VLEN) vlen_r <= root;
    end
    if (cmd.fin_mul)
      prod_r <= acc_rd * $signed({1'b0, wsel});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) acc_r[i] <= '0;
      wsum_r[0]   <= '0;
      wsum_r[1]   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.job_store && cmd.sel != JOB_DIST && cmd.sel != JOB_VLEN)
        acc_r[asel] <= asat;
      if (cmd.fin_add)
        wsum_r[cmd.sel[0]] <= wcur + WsumW'(wq);
      if (cmd.emit) begin
        for (int i = 0; i < 6; i++) acc_r[i] <= '0;
        wsum_r[0]   <= '0;
        wsum_r[1]   <= '0;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      fx_r <= sat_force(wsum_r[0]);
      fy_r <= sat_force(wsum_r[1]);
    end
  end

  assign sts.job_en    = {ali_en, ali_en, coh_en, coh_en, sep_en, sep_en, ali_en, coh_en};
  assign sts.iter_done = iter_done;
  assign sts.iter_busy = iter_busy;
  assign sts.last      = last_r;
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid   = out_valid_r;
  assign out_force_x = fx_r;
  assign out_force_y = fy_r;

endmodule

FILE: rtl/core/bff_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bff_ctrl
// Sequencer: squaring steps, root/divide jobs, weighting and result hand-off.
// ----------------------------------------------------------------------------
module bff_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  bff_pkg::bff_sts_t  sts,
  output bff_pkg::bff_cmd_t  cmd
);
  import bff_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_MUL   = 7'b0000010,
    S_JOB   = 7'b0000100,
    S_JWAIT = 7'b0001000,
    S_FMUL  = 7'b0010000,
    S_FADD  = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.sel   = cnt_r;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = MUL_DX;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        if (cnt_r == MUL_AR) begin
          cnt_nxt   = JOB_DIST;
          state_nxt = S_JOB;
        end else begin
          cnt_nxt = cnt_r + 3'd1;
        end
      end
      S_JOB: begin
        if (sts.job_en[cnt_r]) begin
          cmd.job_start = 1'b1;
          state_nxt     = S_JWAIT;
        end else if (cnt_r == JOB_ALI_Y) begin
          cnt_nxt   = '0;
          state_nxt = sts.last ? S_FMUL : S_IDLE;
        end else begin
          cnt_nxt = cnt_r + 3'd1;
        end
      end
      S_JWAIT: begin
        if (sts.iter_done) begin
          cmd.job_store = 1'b1;
          if (cnt_r == JOB_ALI_Y) begin
            cnt_nxt   = '0;
            state_nxt = sts.last ? S_FMUL : S_IDLE;
          end else begin
            cnt_nxt   = cnt_r + 3'd1;
            state_nxt = S_JOB;
          end
        end
      end
      S_FMUL: begin
        cmd.fin_mul = 1'b1;
        state_nxt   = S_FADD;
      end
      S_FADD: begin
        cmd.fin_add = 1'b1;
        if (cnt_r == FIN_LAST) begin
          state_nxt = S_EMIT;
        end else begin
          cnt_nxt   = cnt_r + 3'd1;
          state_nxt = S_FMUL;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    sts.iter_busy |-> !cmd.job_start)
    else $error("root/divide unit restarted while busy");

  a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second request taken before first finished");

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sts.iter_done |-> (state_r == S_JWAIT))
    else $error("unit finished outside a wait step");

endmodule

FILE: rtl/core/boid_flocking_force.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// boid_flocking_force
// Flocking steering force of one boid, one neighbour per request.
// ----------------------------------------------------------------------------
// One request is taken at a time. A neighbour that is out of every radius
// starts no job of the shared root/divide unit; when all three rules apply
// it runs 2 roots and 6 quotients at most. A request with last_neighbor
// set then weights the six accumulators before the force goes to the
// output register, where it waits while the next request is taken.
module boid_flocking_force (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [bff_pkg::CoordW-1:0] in_self_x,
  input  logic signed [bff_pkg::CoordW-1:0] in_self_y,
  input  logic signed [bff_pkg::CoordW-1:0] in_other_x,
  input  logic signed [bff_pkg::CoordW-1:0] in_other_y,
  input  logic signed [bff_pkg::CoordW-1:0] in_other_vx,
  input  logic signed [bff_pkg::CoordW-1:0] in_other_vy,
  input  logic                              in_last_neighbor,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [bff_pkg::ForceW-1:0] out_force_x,
  output logic signed [bff_pkg::ForceW-1:0] out_force_y,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [4:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import bff_pkg::*;

  bff_cfg_t cfg;
  bff_cmd_t cmd;
  bff_sts_t sts;

  bff_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bff_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bff_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .cmd              (cmd),
    .sts              (sts),
    .in_self_x        (in_self_x),
    .in_self_y        (in_self_y),
    .in_other_x       (in_other_x),
    .in_other_y       (in_other_y),
    .in_other_vx      (in_other_vx),
    .in_other_vy      (in_other_vy),
    .in_last_neighbor (in_last_neighbor),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_force_x      (out_force_x),
    .out_force_y      (out_force_y)
  );

endmodule
